[rtl/thsm_pkg.sv]
package thsm_pkg;

    localparam int IN_FRAC = 14;

    localparam int TAB_CONT = 0;
    localparam int TAB_EROS = 1;
    localparam int TAB_PEAK = 2;

    localparam int CONT_LEN = 12;
    localparam int EROS_LEN = 10;
    localparam int PEAK_LEN = 6;

    // breakpoint and y in thousandths, sea marks a y taken from sea_level
    typedef struct packed {
        logic signed [31:0] xm;
        logic signed [31:0] ym;
        logic               sea;
    } t_knot;

    localparam t_knot CONT_TAB [CONT_LEN] = '{
        '{800, 130000, 1'b0}, '{800, 180000, 1'b0}, '{800, 160000, 1'b0},
        '{500, 130000, 1'b0}, '{300, 80000, 1'b0}, '{200, 0, 1'b1},
        '{100, 70000, 1'b0}, '{0, 0, 1'b1}, '{-200, 40000, 1'b0},
        '{-500, 20000, 1'b0}, '{-950, 20000, 1'b0}, '{-1000, 190000, 1'b0}
    };

    localparam t_knot EROS_TAB [EROS_LEN] = '{
        '{1000, 50, 1'b0}, '{800, 100, 1'b0}, '{700, 350, 1'b0},
        '{400, 350, 1'b0}, '{300, 110, 1'b0}, '{-200, 200, 1'b0},
        '{-400, 600, 1'b0}, '{-500, 500, 1'b0}, '{-800, 900, 1'b0},
        '{-1000, 1000, 1'b0}
    };

    localparam t_knot PEAK_TAB [PEAK_LEN] = '{
        '{1000, 1000, 1'b0}, '{800, 900, 1'b0}, '{500, 950, 1'b0},
        '{50, 350, 1'b0}, '{-400, 300, 1'b0}, '{-900, 100, 1'b0}
    };

    function automatic int tab_len(input int tab);
        int n;
        unique case (tab)
            TAB_CONT: n = CONT_LEN;
            TAB_EROS: n = EROS_LEN;
            default:  n = PEAK_LEN;
        endcase
        return n;
    endfunction

    function automatic t_knot knot_at(input int tab, input int idx);
        t_knot k;
        unique case (tab)
            TAB_CONT: k = CONT_TAB[idx];
            TAB_EROS: k = EROS_TAB[idx];
            default:  k = PEAK_TAB[idx];
        endcase
        return k;
    endfunction

    // thousandths to fixed point, halves rounded away from zero
    function automatic longint mil_to_fix(input longint m, input int frac);
        longint s;
        s = m * (longint'(1) << frac);
        if (s >= 0) begin
            return (s + 500) / 1000;
        end
        return -((-s + 500) / 1000);
    endfunction

endpackage

[rtl/thsm_if.sv]
interface thsm_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] continentalness;
    logic signed [15:0] erosion;
    logic signed [15:0] peaks;

    modport source (output valid, output continentalness, output erosion, output peaks,
                    input ready);
    modport sink (input valid, input continentalness, input erosion, input peaks,
                  output ready);
endinterface

interface thsm_out_if;
    logic       valid;
    logic       ready;
    logic [8:0] height;

    modport source (output valid, output height, input ready);
    modport sink (input valid, input height, output ready);
endinterface

interface thsm_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] sea_level;

    modport source (output valid, output sea_level, input ready);
    modport sink (input valid, input sea_level, output ready);
endinterface

[rtl/thsm_lane.sv]
module thsm_lane #(
    parameter int FRAC_BITS = 16,
    parameter int TAB = 0
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [15:0]      i_noise,
    input  logic [7:0]              i_sea_level,
    output logic [FRAC_BITS+7:0]    o_y
);

    localparam int F  = FRAC_BITS;
    localparam int N  = thsm_pkg::tab_len(TAB);
    localparam int IW = $clog2(N + 1);
    localparam int XW = F + 2;
    localparam int XE = XW + 1;
    localparam int DW = F;
    localparam int RW = F + 5;
    localparam int PW = 2 * F + 5;
    localparam int QW = 2 * F;
    localparam int YW = F + 9;
    localparam int MW = 2 * F + 10;

    // knot breakpoints and per-segment constants
    logic signed [XW-1:0] c_x   [N];
    logic signed [XW-1:0] c_sx1 [N+1];
    logic [DW-1:0]        c_den [N+1];
    logic [RW-1:0]        c_rcp [N+1];
    logic signed [YW-1:0] c_ya  [N+1];
    logic signed [YW-1:0] c_yb  [N+1];
    logic                 c_sa  [N+1];
    logic                 c_sb  [N+1];

    for (genvar g = 0; g < N; g++) begin : g_knot
        localparam thsm_pkg::t_knot KN = thsm_pkg::knot_at(TAB, g);
        localparam longint XN = thsm_pkg::mil_to_fix(longint'(KN.xm), F);
        assign c_x[g] = XW'(XN);
    end

    // segment 0 and N saturate, segment g lies between knots g-1 and g
    for (genvar g = 0; g <= N; g++) begin : g_seg
        localparam int IA = (g == N) ? N - 1 : g;
        localparam int IB = (g == 0) ? 0 : g - 1;
        localparam thsm_pkg::t_knot KA = thsm_pkg::knot_at(TAB, IA);
        localparam thsm_pkg::t_knot KB = thsm_pkg::knot_at(TAB, IB);
        localparam longint X1  = thsm_pkg::mil_to_fix(longint'(KA.xm), F);
        localparam longint X0  = thsm_pkg::mil_to_fix(longint'(KB.xm), F);
        localparam longint YA  = thsm_pkg::mil_to_fix(longint'(KA.ym), F);
        localparam longint YB  = thsm_pkg::mil_to_fix(longint'(KB.ym), F);
        localparam longint DEN = (g == 0 || g == N) ? 0 : X0 - X1;
        localparam longint RCP = (DEN > 0) ? (longint'(1) << (2 * F)) / DEN : 0;
        assign c_sx1[g] = XW'(X1);
        assign c_den[g] = DW'(DEN);
        assign c_rcp[g] = RW'(RCP);
        assign c_ya[g]  = YW'(YA);
        assign c_yb[g]  = YW'(YB);
        assign c_sa[g]  = KA.sea;
        assign c_sb[g]  = KB.sea;
    end

    logic signed [XW-1:0] v_in;

    if (F >= thsm_pkg::IN_FRAC) begin : g_up
        assign v_in = XW'(i_noise) <<< (F - thsm_pkg::IN_FRAC);
    end else begin : g_dn
        assign v_in = XW'(i_noise >>> (thsm_pkg::IN_FRAC - F));
    end

    // stage 0: segment search
    logic [IW-1:0]        n_idx;
    logic signed [XW-1:0] r_v0;
    logic [IW-1:0]        r_idx0;

    always_comb begin
        n_idx = IW'(N);
        for (int i = N - 1; i >= 0; i--) begin
            if (v_in >= c_x[i]) begin
                n_idx = IW'(i);
            end
        end
    end

    // stage 1: offset into segment
    logic signed [XE-1:0] dx1;
    logic                 sat1;
    logic [DW-1:0]        n_d;
    logic [DW-1:0]        r_d1;
    logic [IW-1:0]        r_idx1;

    assign dx1  = XE'(r_v0) - XE'(c_sx1[r_idx0]);
    assign sat1 = (r_idx0 == '0) || (r_idx0 == IW'(N));
    assign n_d  = sat1 ? '0 : dx1[DW-1:0];

    // stage 2: reciprocal product
    logic [PW-1:0] n_prod;
    logic [PW-1:0] r_prod2;
    logic [DW-1:0] r_d2;
    logic [IW-1:0] r_idx2;

    assign n_prod = PW'(r_d1) * PW'(c_rcp[r_idx1]);

    // stage 3: quotient estimate and remainder
    logic [DW-1:0] q3;
    logic [QW-1:0] num3;
    logic [QW-1:0] qd3;
    logic [QW-1:0] rem3;
    logic [DW-1:0] r_q3;
    logic [DW:0]   r_r3;
    logic [IW-1:0] r_idx3;

    assign q3   = r_prod2[2*F-1:F];
    assign num3 = {r_d2, {F{1'b0}}};
    assign qd3  = QW'(q3) * QW'(c_den[r_idx2]);
    assign rem3 = num3 - qd3;

    // stage 4: corrected fraction and endpoint difference
    logic                 corr4;
    logic signed [YW-1:0] sea_fix;
    logic signed [YW-1:0] n_a;
    logic signed [YW-1:0] n_b;
    logic [DW-1:0]        n_t;
    logic [DW-1:0]        r_t4;
    logic signed [YW-1:0] r_dy4;
    logic signed [YW-1:0] r_a4;

    assign corr4   = (r_r3 >= {1'b0, c_den[r_idx3]});
    assign n_t     = r_q3 + DW'(corr4);
    assign sea_fix = signed'(YW'({i_sea_level, {F{1'b0}}}));
    assign n_a     = c_sa[r_idx3] ? sea_fix : c_ya[r_idx3];
    assign n_b     = c_sb[r_idx3] ? sea_fix : c_yb[r_idx3];

    // stage 5: scale difference
    logic signed [MW-1:0] n_m;
    logic signed [MW-1:0] r_m5;
    logic signed [YW-1:0] r_a5;

    assign n_m = MW'(r_dy4) * MW'(signed'({1'b0, r_t4}));

    // stage 6: add lower endpoint
    logic signed [YW-1:0] n_y;
    logic signed [YW-1:0] r_y6;

    assign n_y = r_a5 + YW'(r_m5 >>> F);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v0    <= v_in;
            r_idx0  <= n_idx;
            r_d1    <= n_d;
            r_idx1  <= r_idx0;
            r_prod2 <= n_prod;
            r_d2    <= r_d1;
            r_idx2  <= r_idx1;
            r_q3    <= q3;
            r_r3    <= rem3[DW:0];
            r_idx3  <= r_idx2;
            r_t4    <= n_t;
            r_dy4   <= n_b - n_a;
            r_a4    <= n_a;
            r_m5    <= n_m;
            r_a5    <= r_a4;
            r_y6    <= n_y;
        end
    end

    assign o_y = r_y6[F+7:0];

endmodule

[rtl/thsm_mix.sv]
module thsm_mix #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [FRAC_BITS+7:0] i_base,
    input  logic [FRAC_BITS+7:0] i_ero,
    input  logic [FRAC_BITS+7:0] i_pk,
    output logic [8:0]           o_height
);

    localparam int F  = FRAC_BITS;
    localparam int EW = F + 1;
    localparam int PW = 2 * F + 2;
    localparam int SW = 2 * F + 7;
    localparam int HW = F + 9;

    logic [PW-1:0]  r_ep;
    logic [F+7:0]   r_base;
    logic [SW-1:0]  scaled;
    logic [HW-1:0]  sum;
    logic [8:0]     r_h;

    // twenty times the product, as sixteen plus four
    assign scaled = {3'b000, r_ep, 2'b00} + {1'b0, r_ep, 4'b0000};
    assign sum    = HW'(r_base) + HW'(scaled[SW-1:F]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ep   <= PW'(i_ero[EW-1:0]) * PW'(i_pk[EW-1:0]);
            r_base <= i_base;
            r_h    <= sum[F+8:F];
        end
    end

    assign o_height = r_h;

endmodule

[rtl/terrain_height_spline_mixer.sv]
// Terrain base height from three Q2.14 noise beats (continentalness, erosion,
// peaks), each mapped through a fixed piecewise-linear curve and mixed as
// base + 20 * erosion * peaks. The block takes one noise beat per clock while
// the height side is not stalled and returns its height beat through seven lane
// stages (segment search, offset, reciprocal multiply, remainder, correction,
// scale, add) and two mix stages. When the height beat is not taken the whole
// pipeline holds and the noise side is not ready. The sea_level port is always
// ready; write it only while no beat is in flight.
module terrain_height_spline_mixer #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    thsm_in_if.sink       i_noise,
    thsm_cfg_if.sink      i_cfg,
    thsm_out_if.source    o_height
);

    localparam int LANE_STAGES = 7;
    localparam int MIX_STAGES  = 2;
    localparam int PIPE_DEPTH  = LANE_STAGES + MIX_STAGES;
    localparam logic [7:0] SEA_RESET = 8'd64;

    logic                    pipe_en;
    logic [PIPE_DEPTH-1:0]   r_vld;
    logic [PIPE_DEPTH-1:0]   n_vld;
    logic [7:0]              r_sea;
    logic [7:0]              n_sea;
    logic [FRAC_BITS+7:0]    y_cont;
    logic [FRAC_BITS+7:0]    y_eros;
    logic [FRAC_BITS+7:0]    y_peak;

    assign pipe_en         = !r_vld[PIPE_DEPTH-1] || o_height.ready;
    assign n_vld           = {r_vld[PIPE_DEPTH-2:0], i_noise.valid};
    assign n_sea           = i_cfg.valid ? i_cfg.sea_level : r_sea;
    assign i_noise.ready   = pipe_en;
    assign i_cfg.ready     = 1'b1;
    assign o_height.valid  = r_vld[PIPE_DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_sea <= SEA_RESET;
        end else begin
            r_sea <= n_sea;
            if (pipe_en) begin
                r_vld <= n_vld;
            end
        end
    end

    thsm_lane #(
        .FRAC_BITS (FRAC_BITS),
        .TAB       (thsm_pkg::TAB_CONT)
    ) u_cont (
        .i_clk       (i_clk),
        .i_en        (pipe_en),
        .i_noise     (i_noise.continentalness),
        .i_sea_level (r_sea),
        .o_y         (y_cont)
    );

    thsm_lane #(
        .FRAC_BITS (FRAC_BITS),
        .TAB       (thsm_pkg::TAB_EROS)
    ) u_eros (
        .i_clk       (i_clk),
        .i_en        (pipe_en),
        .i_noise     (i_noise.erosion),
        .i_sea_level (r_sea),
        .o_y         (y_eros)
    );

    thsm_lane #(
        .FRAC_BITS (FRAC_BITS),
        .TAB       (thsm_pkg::TAB_PEAK)
    ) u_peak (
        .i_clk       (i_clk),
        .i_en        (pipe_en),
        .i_noise     (i_noise.peaks),
        .i_sea_level (r_sea),
        .o_y         (y_peak)
    );

    thsm_mix #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mix (
        .i_clk    (i_clk),
        .i_en     (pipe_en),
        .i_base   (y_cont),
        .i_ero    (y_eros),
        .i_pk     (y_peak),
        .o_height (o_height.height)
    );

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_height.valid && !o_height.ready |-> !i_noise.ready)
        else $error("input taken while result beat stalled");

    a_beat_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_noise.valid && i_noise.ready |=> r_vld[0])
        else $error("accepted beat missing from pipeline");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !pipe_en |=> $stable(r_vld))
        else $error("pipeline moved during stall");

    a_sea_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg.valid && i_cfg.ready |=> r_sea == $past(i_cfg.sea_level))
        else $error("sea level write lost");

    a_height_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_height.valid |-> o_height.height <= 9'd275)
        else $error("height out of range");

endmodule
